// File: hdl/ccqe_pkg.sv
// shared widths, constants and status codes of the quasi-elastic energy block
package ccqe_pkg;

  localparam int FRAC_BITS = 4;
  localparam int IN_W      = 20;
  localparam int MOM_W     = 21;
  localparam int MAG_W     = 21;
  localparam int BIND_W    = 11;
  localparam int OUT_W     = 24;
  localparam int STAT_W    = 2;
  localparam int EU_W      = 30;
  localparam int A_W       = 24;
  localparam int SQ_W      = 42;
  localparam int RAD_W     = 60;
  localparam int ROOT_W    = 30;
  localparam int AA_W      = 48;
  localparam int AE_W      = 54;
  localparam int NUM_W     = 57;
  localparam int PROD_W    = 51;
  localparam int DVD_W     = 56;
  localparam int DVS_W     = 42;
  localparam int DEN_W     = 32;
  localparam int QUO_W     = 30;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = QUO_W + 1;

  localparam logic [9:0]        KEV_PER_MEV = 10'd1000;
  localparam logic [10:0]       DEN_SCALE   = 11'd2000;
  localparam logic [BIND_W-1:0] BIND_RESET  = 11'd480;

  localparam logic [A_W-1:0]   MN_U = A_W'(939565 << FRAC_BITS);
  localparam logic [A_W-1:0]   MP_U = A_W'(938272 << FRAC_BITS);
  localparam logic [EU_W-1:0]  ME_U = EU_W'(511 << FRAC_BITS);
  localparam logic [NUM_W-1:0] MP2  = NUM_W'(64'(MP_U) * 64'(MP_U));
  localparam logic [RAD_W-1:0] ME2  = RAD_W'(64'(ME_U) * 64'(ME_U));

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_LOW_ENERGY = 2'd1,
    ST_ZERO_MOM   = 2'd2,
    ST_BAD_DEN    = 2'd3
  } status_e;

endpackage

// File: hdl/ccqe_isqrt.sv
// pipelined integer square root, one root bit per stage
module ccqe_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [ccqe_pkg::RAD_W-1:0]    rad_i,
  output logic                          valid_o,
  output logic [ccqe_pkg::ROOT_W-1:0]   root_o
);

  localparam int RW = ccqe_pkg::RAD_W;
  localparam int QW = ccqe_pkg::ROOT_W;

  logic [QW-1:0] vld_q;
  logic [RW-1:0] rem_q  [QW-1];
  logic [QW-1:0] root_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] root_in;
    logic          vld_in;
    logic [RW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign trial = ((RW+1)'(root_in) << (B + 1)) | ((RW+1)'(1) << (2 * B));
    assign ge    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[s] <= ge ? (root_in | (QW'(1) << B)) : root_in;
    end

    if (s < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? (rem_in - trial[RW-1:0]) : rem_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign root_o  = root_q[QW-1];

endmodule

// File: hdl/ccqe_div.sv
// pipelined restoring divider, range check stage then one quotient bit per stage
module ccqe_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [ccqe_pkg::DVD_W-1:0]  dividend_i,
  input  logic [ccqe_pkg::DVS_W-1:0]  divisor_i,
  output logic                        valid_o,
  output logic [ccqe_pkg::QUO_W-1:0]  quot_o,
  output logic                        ovf_o
);

  localparam int NW = ccqe_pkg::DVD_W;
  localparam int DW = ccqe_pkg::DVS_W;
  localparam int QW = ccqe_pkg::QUO_W;
  localparam int XW = DW + QW;

  logic          pre_vld_q;
  logic [NW-1:0] pre_rem_q;
  logic [DW-1:0] pre_dvs_q;
  logic          pre_ovf_q;

  logic [QW-1:0] vld_q;
  logic [QW-1:0] ovf_q;
  logic [NW-1:0] rem_q  [QW-1];
  logic [DW-1:0] dvs_q  [QW-1];
  logic [QW-1:0] quot_q [QW];

  // quotient must fit the stage count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else begin
      pre_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_rem_q <= dividend_i;
    pre_dvs_q <= divisor_i;
    pre_ovf_q <= XW'(dividend_i) >= (XW'(divisor_i) << QW);
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] dvs_in;
    logic [QW-1:0] quot_in;
    logic          vld_in;
    logic          ovf_in;
    logic [XW-1:0] shifted;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = pre_rem_q;
      assign dvs_in  = pre_dvs_q;
      assign quot_in = '0;
      assign vld_in  = pre_vld_q;
      assign ovf_in  = pre_ovf_q;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign quot_in = quot_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign ovf_in  = ovf_q[s-1];
    end

    assign shifted = XW'(dvs_in) << B;
    assign ge      = XW'(rem_in) >= shifted;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quot_q[s] <= ge ? (quot_in | (QW'(1) << B)) : quot_in;
      ovf_q[s]  <= ovf_in;
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? (rem_in - shifted[NW-1:0]) : rem_in;
        dvs_q[s] <= dvs_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign ovf_o   = ovf_q[QW-1];

endmodule

// File: hdl/ccqe_neutrino_energy.sv
// top level: quasi-elastic neutrino energy reconstruction pipeline
//
// One electron event is taken on every clock cycle at which start_i is high (busy_o is
// always low, so every start is a transfer). Each event gives exactly one result, shown
// on neutrino_energy_o and status_o for one cycle with done_o high; results come out in
// start order and the receiver cannot stall them. Each event passes through the two
// 30-stage square-root units (lepton momentum and vector length, run side by side), the
// two 31-stage dividers (the scattering cosine term and the final quotient) and the
// seven single register stages around them. Energies are in
// 1/16 MeV; internally they are rescaled to 1/16 keV so that the nucleon masses are
// exact. The result is zero whenever status is nonzero and saturates at its maximum.
// binding_energy is written through cfg_valid_i / cfg_data_i, which is always ready;
// it should only change while no events are in flight.
module ccqe_neutrino_energy (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ccqe_pkg::IN_W-1:0]     lepton_energy_i,
  input  logic signed [ccqe_pkg::MOM_W-1:0] momentum_x_i,
  input  logic signed [ccqe_pkg::MOM_W-1:0] momentum_y_i,
  input  logic signed [ccqe_pkg::MOM_W-1:0] momentum_z_i,
  output logic                          done_o,
  output logic [ccqe_pkg::OUT_W-1:0]    neutrino_energy_o,
  output logic [ccqe_pkg::STAT_W-1:0]   status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ccqe_pkg::BIND_W-1:0]   cfg_data_i
);

  // sideband carried alongside the square-root units
  typedef struct packed {
    logic [ccqe_pkg::EU_W-1:0]  eu;
    logic [ccqe_pkg::A_W-1:0]   a;
    logic [ccqe_pkg::MAG_W-1:0] az;
    logic                       neg;
    logic                       low;
    logic [ccqe_pkg::NUM_W-1:0] num;
  } side_a_t;

  // sideband carried alongside the cosine divider
  typedef struct packed {
    logic [ccqe_pkg::EU_W-1:0]  eu;
    logic [ccqe_pkg::A_W-1:0]   a;
    logic                       neg;
    logic                       low;
    logic                       zero;
    logic [ccqe_pkg::NUM_W-1:0] num;
  } side_b_t;

  // binding energy register
  logic [ccqe_pkg::BIND_W-1:0] bind_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bind_q <= ccqe_pkg::BIND_RESET;
    end else if (cfg_valid_i) begin
      bind_q <= cfg_data_i;
    end
  end

  // stage 1: rescale energy to keV units, magnitudes of the momentum components
  logic                        s1_vld_q;
  logic [ccqe_pkg::EU_W-1:0]   s1_eu_q;
  logic [ccqe_pkg::A_W-1:0]    s1_a_q;
  logic [ccqe_pkg::MAG_W-1:0]  s1_ax_q, s1_ay_q, s1_az_q;
  logic                        s1_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_eu_q  <= ccqe_pkg::EU_W'(lepton_energy_i) * ccqe_pkg::EU_W'(ccqe_pkg::KEV_PER_MEV);
    s1_a_q   <= ccqe_pkg::MN_U
              - ccqe_pkg::A_W'(ccqe_pkg::A_W'(bind_q) * ccqe_pkg::A_W'(ccqe_pkg::KEV_PER_MEV));
    // the most negative component has a magnitude that still fits unsigned
    s1_ax_q  <= momentum_x_i[ccqe_pkg::MOM_W-1] ? (~momentum_x_i + 1'b1) : momentum_x_i;
    s1_ay_q  <= momentum_y_i[ccqe_pkg::MOM_W-1] ? (~momentum_y_i + 1'b1) : momentum_y_i;
    s1_az_q  <= momentum_z_i[ccqe_pkg::MOM_W-1] ? (~momentum_z_i + 1'b1) : momentum_z_i;
    s1_neg_q <= momentum_z_i[ccqe_pkg::MOM_W-1];
  end

  // stage 2: all the squares and products, one multiplier each
  logic                        s2_vld_q;
  logic [ccqe_pkg::RAD_W-1:0]  s2_eu2_q;
  logic [ccqe_pkg::SQ_W-1:0]   s2_sx_q, s2_sy_q, s2_sz_q;
  logic [ccqe_pkg::AA_W-1:0]   s2_aa_q;
  logic [ccqe_pkg::AE_W-1:0]   s2_ae_q;
  logic [ccqe_pkg::EU_W-1:0]   s2_eu_q;
  logic [ccqe_pkg::A_W-1:0]    s2_a_q;
  logic [ccqe_pkg::MAG_W-1:0]  s2_az_q;
  logic                        s2_neg_q;
  logic                        s2_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_eu2_q <= ccqe_pkg::RAD_W'(s1_eu_q) * ccqe_pkg::RAD_W'(s1_eu_q);
    s2_sx_q  <= ccqe_pkg::SQ_W'(s1_ax_q) * ccqe_pkg::SQ_W'(s1_ax_q);
    s2_sy_q  <= ccqe_pkg::SQ_W'(s1_ay_q) * ccqe_pkg::SQ_W'(s1_ay_q);
    s2_sz_q  <= ccqe_pkg::SQ_W'(s1_az_q) * ccqe_pkg::SQ_W'(s1_az_q);
    s2_aa_q  <= ccqe_pkg::AA_W'(s1_a_q) * ccqe_pkg::AA_W'(s1_a_q);
    s2_ae_q  <= ccqe_pkg::AE_W'(s1_a_q) * ccqe_pkg::AE_W'(s1_eu_q);
    s2_eu_q  <= s1_eu_q;
    s2_a_q   <= s1_a_q;
    s2_az_q  <= s1_az_q;
    s2_neg_q <= s1_neg_q;
    s2_low_q <= s1_eu_q < ccqe_pkg::ME_U;
  end

  // stage 3: radicands for both roots and the numerator
  logic                        s3_vld_q;
  logic [ccqe_pkg::RAD_W-1:0]  s3_rad_p_q;
  logic [ccqe_pkg::RAD_W-1:0]  s3_rad_r_q;
  side_a_t                     s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // below the electron mass the momentum root is meaningless, keep it clean
    s3_rad_p_q     <= s2_low_q ? '0 : (s2_eu2_q - ccqe_pkg::ME2);
    s3_rad_r_q     <= ccqe_pkg::RAD_W'(s2_sx_q) + ccqe_pkg::RAD_W'(s2_sy_q)
                    + ccqe_pkg::RAD_W'(s2_sz_q);
    s3_side_q.eu   <= s2_eu_q;
    s3_side_q.a    <= s2_a_q;
    s3_side_q.az   <= s2_az_q;
    s3_side_q.neg  <= s2_neg_q;
    s3_side_q.low  <= s2_low_q;
    // two's complement numerator: Mp^2 - A^2 - Me^2 + 2 A E
    s3_side_q.num  <= ccqe_pkg::MP2 - ccqe_pkg::NUM_W'(s2_aa_q)
                    - ccqe_pkg::NUM_W'(ccqe_pkg::ME2) + ccqe_pkg::NUM_W'({s2_ae_q, 1'b0});
  end

  // momentum magnitude and vector length, side by side
  logic                         sqp_vld, sqr_vld;
  logic [ccqe_pkg::ROOT_W-1:0]  sqp_root, sqr_root;

  ccqe_isqrt u_sqrt_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_p_q),
    .valid_o (sqp_vld),
    .root_o  (sqp_root)
  );

  ccqe_isqrt u_sqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_r_q),
    .valid_o (sqr_vld),
    .root_o  (sqr_root)
  );

  side_a_t side_a_q [ccqe_pkg::SQRT_LAT];

  always_ff @(posedge clk_i) begin
    side_a_q[0] <= s3_side_q;
    for (int i = 1; i < ccqe_pkg::SQRT_LAT; i++) begin
      side_a_q[i] <= side_a_q[i-1];
    end
  end

  // stage 4: p * |pz| ahead of the cosine divide
  logic                         s4_vld_q;
  logic [ccqe_pkg::PROD_W-1:0]  s4_prod_q;
  logic [ccqe_pkg::ROOT_W-1:0]  s4_r_q;
  side_b_t                      s4_side_q;
  side_a_t                      sa_out;

  assign sa_out = side_a_q[ccqe_pkg::SQRT_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= sqp_vld & sqr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_prod_q      <= ccqe_pkg::PROD_W'(sqp_root) * ccqe_pkg::PROD_W'(sa_out.az);
    s4_r_q         <= sqr_root;
    s4_side_q.eu   <= sa_out.eu;
    s4_side_q.a    <= sa_out.a;
    s4_side_q.neg  <= sa_out.neg;
    s4_side_q.low  <= sa_out.low;
    s4_side_q.zero <= sqr_root == '0;
    s4_side_q.num  <= sa_out.num;
  end

  // p * cos = p * |pz| / r, the quotient never exceeds p
  logic                         dq_vld;
  logic [ccqe_pkg::QUO_W-1:0]   dq_quot;
  logic                         dq_ovf;

  ccqe_div u_div_cos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s4_vld_q),
    .dividend_i (ccqe_pkg::DVD_W'(s4_prod_q)),
    .divisor_i  (ccqe_pkg::DVS_W'(s4_r_q)),
    .valid_o    (dq_vld),
    .quot_o     (dq_quot),
    .ovf_o      (dq_ovf)
  );

  side_b_t side_b_q [ccqe_pkg::DIV_LAT];

  always_ff @(posedge clk_i) begin
    side_b_q[0] <= s4_side_q;
    for (int i = 1; i < ccqe_pkg::DIV_LAT; i++) begin
      side_b_q[i] <= side_b_q[i-1];
    end
  end

  // stage 5: denominator and the status code
  side_b_t                          sb_out;
  logic signed [ccqe_pkg::DEN_W-1:0] den;
  logic signed [ccqe_pkg::DEN_W-1:0] q_signed;
  ccqe_pkg::status_e                st5;

  assign sb_out   = side_b_q[ccqe_pkg::DIV_LAT-1];
  assign q_signed = sb_out.neg ? -$signed(ccqe_pkg::DEN_W'(dq_quot))
                               : $signed(ccqe_pkg::DEN_W'(dq_quot));
  assign den      = $signed(ccqe_pkg::DEN_W'(sb_out.a)) - $signed(ccqe_pkg::DEN_W'(sb_out.eu))
                  + q_signed;

  // lowest fault code wins
  always_comb begin
    if (sb_out.low) begin
      st5 = ccqe_pkg::ST_LOW_ENERGY;
    end else if (sb_out.zero || dq_ovf) begin
      st5 = ccqe_pkg::ST_ZERO_MOM;
    end else if (den[ccqe_pkg::DEN_W-1] || den == '0) begin
      st5 = ccqe_pkg::ST_BAD_DEN;
    end else begin
      st5 = ccqe_pkg::ST_OK;
    end
  end

  logic                              s5_vld_q;
  logic [ccqe_pkg::DEN_W-2:0]        s5_den_q;
  logic [ccqe_pkg::NUM_W-1:0]        s5_num_q;
  ccqe_pkg::status_e                 s5_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= dq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_den_q <= den[ccqe_pkg::DEN_W-2:0];
    s5_num_q <= sb_out.num;
    s5_st_q  <= st5;
  end

  // stage 6: scale the denominator, clamp a negative numerator to zero
  logic                         s6_vld_q;
  logic [ccqe_pkg::DVD_W-1:0]   s6_dvd_q;
  logic [ccqe_pkg::DVS_W-1:0]   s6_dvs_q;
  ccqe_pkg::status_e            s6_st_q;
  logic                         num_pos;

  assign num_pos = !s5_num_q[ccqe_pkg::NUM_W-1] && s5_num_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_dvd_q <= num_pos ? s5_num_q[ccqe_pkg::DVD_W-1:0] : '0;
    s6_dvs_q <= ccqe_pkg::DVS_W'(s5_den_q) * ccqe_pkg::DVS_W'(ccqe_pkg::DEN_SCALE);
    s6_st_q  <= s5_st_q;
  end

  // final quotient
  logic                         de_vld;
  logic [ccqe_pkg::QUO_W-1:0]   de_quot;
  logic                         de_ovf;

  ccqe_div u_div_energy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s6_vld_q),
    .dividend_i (s6_dvd_q),
    .divisor_i  (s6_dvs_q),
    .valid_o    (de_vld),
    .quot_o     (de_quot),
    .ovf_o      (de_ovf)
  );

  ccqe_pkg::status_e st_line_q [ccqe_pkg::DIV_LAT];

  always_ff @(posedge clk_i) begin
    st_line_q[0] <= s6_st_q;
    for (int i = 1; i < ccqe_pkg::DIV_LAT; i++) begin
      st_line_q[i] <= st_line_q[i-1];
    end
  end

  // output register: saturate, zero on any fault
  ccqe_pkg::status_e           st_out;
  logic                        sat;
  logic [ccqe_pkg::OUT_W-1:0]  energy_d;

  assign st_out = st_line_q[ccqe_pkg::DIV_LAT-1];
  assign sat    = de_ovf || (de_quot[ccqe_pkg::QUO_W-1:ccqe_pkg::OUT_W] != '0);

  always_comb begin
    if (st_out != ccqe_pkg::ST_OK) begin
      energy_d = '0;
    end else if (sat) begin
      energy_d = '1;
    end else begin
      energy_d = de_quot[ccqe_pkg::OUT_W-1:0];
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= de_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    neutrino_energy_o <= energy_d;
    status_o          <= st_out;
  end

  assign done_o = done_q;

endmodule

// File: sim/ccqe_check.sv
`timescale 1ns / 100ps
// checker: predicts each neutrino energy result and compares it with the block output
module ccqe_check (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  busy_i,
  input  logic [ccqe_pkg::IN_W-1:0]             lepton_energy_i,
  input  logic signed [ccqe_pkg::MOM_W-1:0]     momentum_x_i,
  input  logic signed [ccqe_pkg::MOM_W-1:0]     momentum_y_i,
  input  logic signed [ccqe_pkg::MOM_W-1:0]     momentum_z_i,
  input  logic                                  done_i,
  input  logic [ccqe_pkg::OUT_W-1:0]            neutrino_energy_i,
  input  logic [ccqe_pkg::STAT_W-1:0]           status_i,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [ccqe_pkg::BIND_W-1:0]           cfg_data_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  typedef struct {
    logic [ccqe_pkg::OUT_W-1:0] energy;
    ccqe_pkg::status_e          status;
  } nu_result_t;

  localparam longint MN_KU = 939565 * 16;
  localparam longint MP_KU = 938272 * 16;
  localparam longint ME_KU = 511 * 16;
  localparam longint SAT   = 16777215;

  nu_result_t                  awaited_q[$];
  logic [ccqe_pkg::BIND_W-1:0] bind_model;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic nu_result_t reconstruct_nu(logic [ccqe_pkg::IN_W-1:0] e_port,
      logic signed [ccqe_pkg::MOM_W-1:0] px, logic signed [ccqe_pkg::MOM_W-1:0] py,
      logic signed [ccqe_pkg::MOM_W-1:0] pz, logic [ccqe_pkg::BIND_W-1:0] bind_e);
    nu_result_t      r;
    longint          eu, a, qv, den, num;
    longint unsigned ax, ay, az, len, pmag, quo;
    r.energy = '0;
    r.status = ccqe_pkg::ST_OK;
    eu = longint'(e_port) * 1000;
    a  = MN_KU - longint'(bind_e) * 1000;
    ax = (px < 0) ? -longint'(px) : longint'(px);
    ay = (py < 0) ? -longint'(py) : longint'(py);
    az = (pz < 0) ? -longint'(pz) : longint'(pz);
    // lowest fault code wins
    if (eu < ME_KU) begin
      r.status = ccqe_pkg::ST_LOW_ENERGY;
    end else begin
      len = int_root(ax * ax + ay * ay + az * az);
      if (len == 0) begin
        r.status = ccqe_pkg::ST_ZERO_MOM;
      end else begin
        pmag = int_root(longint'(eu * eu) - ME_KU * ME_KU);
        qv   = longint'((pmag * az) / len);
        if (pz < 0) qv = -qv;
        den = a - eu + qv;
        if (den <= 0) begin
          r.status = ccqe_pkg::ST_BAD_DEN;
        end else begin
          num = MP_KU * MP_KU - a * a - ME_KU * ME_KU + 2 * a * eu;
          // negative numerator clamps to zero with status ok
          if (num > 0) begin
            quo = longint'(num) / (longint'(den) * 2000);
            r.energy = (quo > SAT) ? ccqe_pkg::OUT_W'(SAT) : ccqe_pkg::OUT_W'(quo);
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nu_result_t want;
    if (!rst_ni) begin
      bind_model   <= ccqe_pkg::BIND_RESET;
      fail_count_o <= 0;
      awaited_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) bind_model <= cfg_data_i;
      if (start_i && !busy_i)
        awaited_q.push_back(reconstruct_nu(lepton_energy_i, momentum_x_i,
                                           momentum_y_i, momentum_z_i, bind_model));
      if (done_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result energy %0d status %0d", $time,
                   neutrino_energy_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = awaited_q.pop_front();
          if (want.energy !== neutrino_energy_i || want.status !== status_i) begin
            $display("%0t: mismatch expected energy %0d status %0d, got energy %0d status %0d",
                     $time, want.energy, want.status, neutrino_energy_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = awaited_q.size();

endmodule

// File: sim/ccqe_neutrino_energy_tb.sv
`timescale 1ns / 100ps
// testbench top: stimulus, binding energy settings and verdict for the energy block
module ccqe_neutrino_energy_tb;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start_i = 1'b0;
  logic                               busy_o;
  logic [ccqe_pkg::IN_W-1:0]          lepton_energy_i = '0;
  logic signed [ccqe_pkg::MOM_W-1:0]  momentum_x_i = '0;
  logic signed [ccqe_pkg::MOM_W-1:0]  momentum_y_i = '0;
  logic signed [ccqe_pkg::MOM_W-1:0]  momentum_z_i = '0;
  logic                               done_o;
  logic [ccqe_pkg::OUT_W-1:0]         neutrino_energy_o;
  logic [ccqe_pkg::STAT_W-1:0]        status_o;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [ccqe_pkg::BIND_W-1:0]        cfg_data_i = '0;
  int                                 fail_count;
  int                                 pending;
  int                                 events_sent = 0;
  int                                 settings_used = 1;

  // 20 ns period
  always #10 clk_i = ~clk_i;

  ccqe_neutrino_energy dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .lepton_energy_i,
    .momentum_x_i, .momentum_y_i, .momentum_z_i,
    .done_o, .neutrino_energy_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  ccqe_check checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .lepton_energy_i,
    .momentum_x_i, .momentum_y_i, .momentum_z_i,
    .done_i(done_o), .neutrino_energy_i(neutrino_energy_o), .status_i(status_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // one event transfer; called and returning at a falling edge, start left high
  task automatic send_event(int gap_pct, logic [ccqe_pkg::IN_W-1:0] e,
                            logic signed [ccqe_pkg::MOM_W-1:0] x,
                            logic signed [ccqe_pkg::MOM_W-1:0] y,
                            logic signed [ccqe_pkg::MOM_W-1:0] z);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i         <= 1'b1;
    lepton_energy_i <= e;
    momentum_x_i    <= x;
    momentum_y_i    <= y;
    momentum_z_i    <= z;
    // busy only moves after a rising edge, so its value now holds at the next edge
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    events_sent++;
  endtask

  // stop sending and let every result drain, then allow the pipeline latency
  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (110) @(negedge clk_i);
  endtask

  // binding energy write while nothing is in flight
  task automatic write_binding(logic [ccqe_pkg::BIND_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  // random event: mostly physical electrons, some full-range noise
  task automatic send_random(int gap_pct);
    logic [ccqe_pkg::IN_W-1:0]         e;
    logic signed [ccqe_pkg::MOM_W-1:0] x, y, z;
    int                                kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      e = ccqe_pkg::IN_W'($urandom_range(8, 40000));
      x = ccqe_pkg::MOM_W'($signed(ccqe_pkg::MOM_W'($urandom_range(0, 2 * 40000))) - 40000);
      y = ccqe_pkg::MOM_W'($signed(ccqe_pkg::MOM_W'($urandom_range(0, 2 * 40000))) - 40000);
      z = ccqe_pkg::MOM_W'($signed(ccqe_pkg::MOM_W'($urandom_range(0, 2 * 40000))) - 40000);
    end else if (kind < 7) begin
      // near the pole of the denominator so saturation shows up
      e = ccqe_pkg::IN_W'($urandom_range(14000, 15100));
      x = ccqe_pkg::MOM_W'($signed(ccqe_pkg::MOM_W'($urandom_range(0, 64))) - 32);
      y = ccqe_pkg::MOM_W'($signed(ccqe_pkg::MOM_W'($urandom_range(0, 64))) - 32);
      z = ccqe_pkg::MOM_W'($signed(ccqe_pkg::MOM_W'($urandom_range(0, 64))) - 32);
    end else begin
      e = ccqe_pkg::IN_W'($urandom);
      x = ccqe_pkg::MOM_W'($urandom);
      y = ccqe_pkg::MOM_W'($urandom);
      z = ccqe_pkg::MOM_W'($urandom);
    end
    send_event(gap_pct, e, x, y, z);
  endtask

  initial begin
    logic signed [ccqe_pkg::MOM_W-1:0] pmax, pmin;
    pmax = {1'b0, {(ccqe_pkg::MOM_W-1){1'b1}}};
    pmin = {1'b1, {(ccqe_pkg::MOM_W-1){1'b0}}};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed events at the reset binding energy
    send_event(0, 0, 100, 0, 0);              // energy below electron mass
    send_event(0, 8, 100, 0, 0);              // just below electron mass
    send_event(0, 9, 0, 0, 10);               // just above electron mass
    send_event(0, 5000, 0, 0, 0);             // zero momentum vector
    send_event(0, 0, 0, 0, 0);                // low energy and zero momentum at once
    send_event(0, '1, 0, 0, -1);              // denominator negative
    send_event(0, '1, pmax, pmax, pmax);
    send_event(0, '1, pmin, pmin, pmin);
    send_event(0, '1, pmin, 0, pmax);
    send_event(0, 15003, 1, 0, 0);            // denominator negative
    send_event(0, 14000, 0, 0, 5);
    send_event(0, 3200, 100, -200, 3000);
    send_event(0, 16000, 0, 0, pmin);         // large backward pz, bad denominator
    send_event(0, 800, -1, -1, pmax);
    send_event(0, '1, 1, 1, 1);
    drain_results();

    // no binding energy: small energies give a negative numerator
    write_binding(0);
    send_event(0, 9, 0, 0, 1);
    send_event(0, 20, 3, 4, 0);
    send_event(0, 15033, 0, 1, 0);
    send_event(0, '1, pmax, 0, pmax);
    send_event(0, 3000, 0, 0, -100);
    drain_results();

    // random phases, each with its own binding energy and idling pattern
    write_binding(1600);
    repeat (170) send_random(0);
    drain_results();
    write_binding('1);
    repeat (170) send_random(55);
    drain_results();
    write_binding(ccqe_pkg::BIND_W'($urandom_range(1, 1599)));
    repeat (170) send_random(6);
    drain_results();
    write_binding(ccqe_pkg::BIND_RESET);
    repeat (170) send_random($urandom_range(1) ? 0 : 55);
    drain_results();

    $display("run covered %0d events over %0d binding energy settings,", events_sent,
             settings_used);
    $display("with fault, saturation and clamp cases and several sender idling patterns");
    if (fail_count == 0 && pending == 0) begin
      $display("[ccqe_neutrino_energy] OK");
    end else begin
      $display("[ccqe_neutrino_energy] ERROR");
    end
    $finish;
  end

  // run limit far above the slowest correct run
  initial begin
    #5_000_000;
    $display("[ccqe_neutrino_energy] ERROR");
    $finish;
  end

endmodule

// File: sim.f
hdl/ccqe_pkg.sv
hdl/ccqe_isqrt.sv
hdl/ccqe_div.sv
hdl/ccqe_neutrino_energy.sv
sim/ccqe_check.sv
sim/ccqe_neutrino_energy_tb.sv
